[src/assert_macros.svh]
// Assertion macros used by the top level of the run generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

[src/rsg_pkg.sv]
// Package with the record type, widths and key compare of the run generator.
`default_nettype none
package rsg_pkg;
    localparam int HEAP_DEPTH_DEFAULT = 256;
    localparam int LIMIT_W = 9;
    localparam int RUN_W = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0] payload;
    } record_t;

    function automatic logic key_less(record_t a, record_t b);
        return $signed(a.key) < $signed(b.key);
    endfunction
endpackage
`default_nettype wire

[src/rsg_store.sv]
// Record store: one write port and two registered read ports with write forwarding.
`default_nettype none
module rsg_store #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  wire logic           clk,
    input  wire logic           we,
    input  wire logic [AW-1:0]  waddr,
    input  wire rsg_pkg::record_t wdata,
    input  wire logic [AW-1:0]  raddr0,
    input  wire logic [AW-1:0]  raddr1,
    output rsg_pkg::record_t    rdata0,
    output rsg_pkg::record_t    rdata1
);
    import rsg_pkg::*;

    record_t mem [DEPTH];
    record_t rd0_reg;
    record_t rd1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= (we && waddr == raddr0) ? wdata : mem[raddr0];
        rd1_reg <= (we && waddr == raddr1) ? wdata : mem[raddr1];
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;
endmodule
`default_nettype wire

[src/replacement_selection_run_generator.sv]
// Top level of the replacement-selection run generator.
// Records fill a min-heap held in a HEAP_DEPTH-entry record memory (256 by default) until
// heap_limit records are stored; after that each record emits the heap minimum into the
// current run, and drain items emit the remaining records run by run. One item is worked
// on at a time and the next is taken once the previous one is finished; an emitting
// record or a drain item that pops a record first leaves its result in the output
// register. Each heap level of a sift-up or sift-down waits for a memory read. When a
// run closes, the parked records are rebuilt into a heap by a sift-down of each of the
// first half of the parked records. There is no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"
module replacement_selection_run_generator #(
    parameter int HEAP_DEPTH = rsg_pkg::HEAP_DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rsg_pkg::LIMIT_W-1:0] heap_limit,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        kind,
    input  wire logic signed [31:0]          key,
    input  wire logic [31:0]                 payload,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [31:0]               out_key,
    output logic [31:0]                      out_payload,
    output logic [rsg_pkg::RUN_W-1:0]        run_number,
    output logic                             last_of_run,
    output logic                             store_empty
);
    import rsg_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int IW = AW + 2;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MOVE_H   = 4'd1;
    localparam logic [3:0] S_SU_START = 4'd2;
    localparam logic [3:0] S_SU_CMP   = 4'd3;
    localparam logic [3:0] S_EM_RD    = 4'd4;
    localparam logic [3:0] S_DR_RD    = 4'd5;
    localparam logic [3:0] S_DR_MV    = 4'd6;
    localparam logic [3:0] S_SD_START = 4'd7;
    localparam logic [3:0] S_SD_CMP   = 4'd8;
    localparam logic [3:0] S_SD_END   = 4'd9;
    localparam logic [3:0] S_CLOSE    = 4'd10;
    localparam logic [3:0] S_HP_RD    = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]         state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [CW-1:0]      active_reg, active_next;
    logic [CW-1:0]      held_reg, held_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic               draining_reg, draining_next;
    record_t            x_reg, x_next;
    record_t            top_reg, top_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      last_reg, last_next;
    logic               heap_phase_reg, heap_phase_next;
    logic               drain_op_reg, drain_op_next;
    logic               last_flag_reg, last_flag_next;
    logic               empty_flag_reg, empty_flag_next;
    logic [RUN_W-1:0]   res_run_reg, res_run_next;
    logic               out_valid_reg, out_valid_next;
    record_t            out_rec_reg, out_rec_next;
    logic [RUN_W-1:0]   out_run_reg, out_run_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    record_t            mem_wdata;
    logic [AW-1:0]      mem_raddr0;
    logic [AW-1:0]      mem_raddr1;
    record_t            rd0;
    record_t            rd1;

    logic               in_fire;
    record_t            rec_in;
    logic [CW-1:0]      total;
    logic [LW-1:0]      lim_eff;
    logic [LW-1:0]      total_ext;
    logic [AW-1:0]      last_idx;
    logic [AW-1:0]      parent_i;
    logic [AW-1:0]      parent_p;
    logic [IW-1:0]      n_ext;
    logic [IW-1:0]      left_i;
    logic [IW-1:0]      right_i;
    logic               right_pick;
    logic [IW-1:0]      child;
    record_t            child_rec;
    logic [IW-1:0]      left_c;

    rsg_store #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    assign cfg_ready = 1'b1;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign rec_in = '{key: key, payload: payload};
    assign total = active_reg + held_reg;
    assign total_ext = LW'(total);
    assign last_idx = AW'(active_reg - CW'(1));
    assign parent_i = AW'((i_reg - AW'(1)) >> 1);
    assign parent_p = AW'((parent_i - AW'(1)) >> 1);
    assign n_ext = IW'(n_reg);
    assign left_i = (IW'(i_reg) << 1) + IW'(1);
    assign right_i = left_i + IW'(1);
    assign right_pick = (right_i < n_ext) && key_less(rd1, rd0);
    assign child = right_pick ? right_i : left_i;
    assign child_rec = right_pick ? rd1 : rd0;
    assign left_c = (child << 1) + IW'(1);

    always_comb
    begin
        lim_eff = LW'(limit_reg);
        if (lim_eff == '0)
        begin
            lim_eff = LW'(1);
        end
        if (lim_eff > LW'(HEAP_DEPTH))
        begin
            lim_eff = LW'(HEAP_DEPTH);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        limit_next = (cfg_valid && cfg_ready) ? heap_limit : limit_reg;
        active_next = active_reg;
        held_next = held_reg;
        run_next = run_reg;
        draining_next = draining_reg;
        x_next = x_reg;
        top_next = top_reg;
        i_next = i_reg;
        n_next = n_reg;
        hi_next = hi_reg;
        last_next = last_reg;
        heap_phase_next = heap_phase_reg;
        drain_op_next = drain_op_reg;
        last_flag_next = last_flag_reg;
        empty_flag_next = empty_flag_reg;
        res_run_next = res_run_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rec_next = out_rec_reg;
        out_run_next = out_run_reg;
        out_last_next = out_last_reg;
        out_empty_next = out_empty_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = x_reg;
        mem_raddr0 = '0;
        mem_raddr1 = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_flag_next = 1'b0;
                    empty_flag_next = 1'b0;
                    heap_phase_next = 1'b0;
                    res_run_next = run_reg;
                    last_next = last_idx;
                    if (kind == 1'b0)
                    begin
                        drain_op_next = 1'b0;
                        if (draining_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (total_ext < lim_eff || active_reg == '0)
                        begin
                            if (total != CW'(HEAP_DEPTH))
                            begin
                                x_next = rec_in;
                                i_next = AW'(active_reg);
                                active_next = active_reg + CW'(1);
                                mem_raddr0 = AW'(active_reg);
                                state_next = (held_reg != '0) ? S_MOVE_H : S_SU_START;
                            end
                        end
                        else
                        begin
                            x_next = rec_in;
                            mem_raddr0 = '0;
                            mem_raddr1 = last_idx;
                            state_next = S_EM_RD;
                        end
                    end
                    else
                    begin
                        drain_op_next = 1'b1;
                        if (total == '0 || active_reg == '0)
                        begin
                            draining_next = 1'b0;
                        end
                        else
                        begin
                            draining_next = 1'b1;
                            mem_raddr0 = '0;
                            mem_raddr1 = last_idx;
                            state_next = S_DR_RD;
                        end
                    end
                end
            end
            S_MOVE_H:
            begin
                mem_we = 1'b1;
                mem_waddr = AW'(CW'(i_reg) + held_reg);
                mem_wdata = rd0;
                state_next = S_SU_START;
            end
            S_SU_START:
            begin
                if (i_reg == '0)
                begin
                    mem_we = 1'b1;
                    mem_waddr = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_raddr0 = parent_i;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                mem_we = 1'b1;
                mem_waddr = i_reg;
                if (key_less(x_reg, rd0))
                begin
                    mem_wdata = rd0;
                    i_next = parent_i;
                    if (parent_i == '0)
                    begin
                        state_next = S_SU_START;
                    end
                    else
                    begin
                        mem_raddr0 = parent_p;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EM_RD:
            begin
                top_next = rd0;
                i_next = '0;
                if (!key_less(x_reg, rd0))
                begin
                    n_next = active_reg;
                end
                else
                begin
                    x_next = rd1;
                    mem_we = 1'b1;
                    mem_waddr = last_reg;
                    active_next = active_reg - CW'(1);
                    held_next = held_reg + CW'(1);
                    n_next = active_reg - CW'(1);
                end
                state_next = S_SD_START;
            end
            S_DR_RD:
            begin
                top_next = rd0;
                x_next = rd1;
                i_next = '0;
                active_next = active_reg - CW'(1);
                n_next = active_reg - CW'(1);
                if (held_reg != '0)
                begin
                    mem_raddr0 = AW'(CW'(last_reg) + held_reg);
                    state_next = S_DR_MV;
                end
                else
                begin
                    state_next = S_SD_START;
                end
            end
            S_DR_MV:
            begin
                mem_we = 1'b1;
                mem_waddr = last_reg;
                mem_wdata = rd0;
                state_next = S_SD_START;
            end
            S_SD_START:
            begin
                if (left_i >= n_ext)
                begin
                    if (IW'(i_reg) < n_ext)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = i_reg;
                    end
                    state_next = S_SD_END;
                end
                else
                begin
                    mem_raddr0 = AW'(left_i);
                    mem_raddr1 = AW'(right_i);
                    state_next = S_SD_CMP;
                end
            end
            S_SD_CMP:
            begin
                mem_we = 1'b1;
                mem_waddr = i_reg;
                if (key_less(child_rec, x_reg))
                begin
                    mem_wdata = child_rec;
                    i_next = AW'(child);
                    if (left_c < n_ext)
                    begin
                        mem_raddr0 = AW'(left_c);
                        mem_raddr1 = AW'(left_c + IW'(1));
                    end
                    else
                    begin
                        state_next = S_SD_START;
                    end
                end
                else
                begin
                    state_next = S_SD_END;
                end
            end
            S_SD_END:
            begin
                if (!heap_phase_reg)
                begin
                    state_next = S_CLOSE;
                end
                else if (hi_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    hi_next = hi_reg - AW'(1);
                    i_next = hi_reg - AW'(1);
                    mem_raddr0 = hi_reg - AW'(1);
                    state_next = S_HP_RD;
                end
            end
            S_CLOSE:
            begin
                if (active_reg == '0)
                begin
                    run_next = run_reg + RUN_W'(1);
                    active_next = held_reg;
                    held_next = '0;
                    n_next = held_reg;
                    hi_next = AW'(held_reg >> 1);
                    last_flag_next = 1'b1;
                    heap_phase_next = 1'b1;
                    state_next = S_SD_END;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_HP_RD:
            begin
                x_next = rd0;
                state_next = S_SD_START;
            end
            S_FINISH:
            begin
                if (drain_op_reg && total == '0)
                begin
                    empty_flag_next = 1'b1;
                    draining_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next = top_reg;
                    out_run_next = res_run_reg;
                    out_last_next = last_flag_reg;
                    out_empty_next = empty_flag_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= LIMIT_RESET;
            active_reg <= '0;
            held_reg <= '0;
            run_reg <= '0;
            draining_reg <= 1'b0;
            heap_phase_reg <= 1'b0;
            drain_op_reg <= 1'b0;
            last_flag_reg <= 1'b0;
            empty_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            limit_reg <= limit_next;
            active_reg <= active_next;
            held_reg <= held_next;
            run_reg <= run_next;
            draining_reg <= draining_next;
            heap_phase_reg <= heap_phase_next;
            drain_op_reg <= drain_op_next;
            last_flag_reg <= last_flag_next;
            empty_flag_reg <= empty_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        top_reg <= top_next;
        i_reg <= i_next;
        n_reg <= n_next;
        hi_reg <= hi_next;
        last_reg <= last_next;
        res_run_reg <= res_run_next;
        out_rec_reg <= out_rec_next;
        out_run_reg <= out_run_next;
        out_last_reg <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign out_key = out_rec_reg.key;
    assign out_payload = out_rec_reg.payload;
    assign run_number = out_run_reg;
    assign last_of_run = out_last_reg;
    assign store_empty = out_empty_reg;

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, ({1'b0, active_reg} + {1'b0, held_reg}) <= (CW+1)'(HEAP_DEPTH))
    `ASSERT_NEXT(a_drain_busy, clk, rst_n, in_fire && kind && active_reg != '0, state_reg != S_IDLE)
    `ASSERT_IMPL(a_load_from_done, clk, rst_n, out_valid_reg && !$past(out_valid_reg), $past(state_reg) == S_DONE)
    `ASSERT_IMPL(a_pop_nonempty, clk, rst_n, state_reg == S_EM_RD || state_reg == S_DR_RD, active_reg != '0)
endmodule
`default_nettype wire
